/* rtl/core/timing_wheel_scheduler_macros.svh */
// Assertion macros shared by the timing wheel scheduler checker.
// Each macro samples on the rising clock edge and is disabled while reset is low.
`ifndef TIMING_WHEEL_SCHEDULER_MACROS_SVH
`define TIMING_WHEEL_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define TWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tws_pkg.sv */
// Package for the timing wheel scheduler: field widths, codes and default sizes.
// No dependencies; used by the top level, both checkers and the testbench.
package tws_pkg;

  localparam int NUM_BUCKETS_DEF      = 64;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  localparam int MODE_W    = 2;
  localparam int TIMEOUT_W = 32;
  localparam int TAG_W     = 16;
  localparam int HANDLE_W  = 9;
  localparam int TD_W      = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 32;

  localparam logic [TD_W-1:0] TD_RESET = 16'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_REPLY    = 2'd0,
    KIND_FIRED        = 2'd1,
    KIND_REMOVE_REPLY = 2'd2,
    KIND_TICK_DONE    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_MODIFY,
    ST_TICK_SCAN,
    ST_TICK_TAG
  } state_e;

endpackage

/* rtl/core/tws_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; the timing wheel scheduler holds its bucket rows and tags in it.
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/timing_wheel_scheduler.sv */
// Timing wheel scheduler, one item at a time. For an add a 32-step radix-2 divider splits the
// timeout by tick_duration; unless it is too long, a row read and, if a slot is free, a row write follow.
// For a remove a constant reciprocal multiply splits the handle; a handle on the wheel then gets the same.
// A tick walks the slots of the current bucket, reads the tag of each fired entry, then writes the row back.
// Results wait in an output register; a stall there holds the block. Needs tws_pkg, tws_ram.
// After reset a clearing pass zeroes the rows; no item is taken before.
module timing_wheel_scheduler #(
  parameter int NUM_BUCKETS      = tws_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = tws_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write: tick_duration.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tws_pkg::TD_W-1:0]        cfg_data_i,
  // Input items.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // timeout [31:0], one_shot [32], tag [48:33], handle [57:49], zero [63:58]
  input  logic [tws_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // mode [1:0]
  input  logic [tws_pkg::MODE_W-1:0]      s_axis_tuser_i,
  // Result items.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status [1:0], result_handle [10:2], fired_tag [26:11], zero [31:27]
  output logic [tws_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // kind [1:0]
  output logic [tws_pkg::KIND_W-1:0]      m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam int BW      = $clog2(NUM_BUCKETS);
  localparam int SW      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SCW     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int ENTRIES = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int IW      = $clog2(ENTRIES);
  localparam int ROW_W   = 2 * SLOTS_PER_BUCKET;
  localparam int DIV_CW  = $clog2(tws_pkg::TIMEOUT_W + 1);

  // Handle split: bucket = (handle * RM_RECIP) >> RM_SHIFT is exact for every 9-bit handle.
  localparam int RM_SHIFT = tws_pkg::HANDLE_W + $clog2(SLOTS_PER_BUCKET);
  localparam int RM_RECIP = ((1 << RM_SHIFT) + SLOTS_PER_BUCKET - 1) / SLOTS_PER_BUCKET;
  localparam int RM_PW    = tws_pkg::HANDLE_W + RM_SHIFT + 1;

  localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);
  localparam logic [BW:0]   NB_EXT      = (BW + 1)'(NUM_BUCKETS);

  // Control and datapath registers.
  tws_pkg::state_e state_q, state_d;
  tws_pkg::mode_e  mode_q, mode_d;
  logic [BW-1:0]                   cur_bucket_q, cur_bucket_d;
  logic [BW-1:0]                   clr_q, clr_d;
  logic [tws_pkg::TD_W-1:0]        td_q;
  logic                            one_shot_q, one_shot_d;
  logic [tws_pkg::TAG_W-1:0]       tag_q, tag_d;
  logic [tws_pkg::TD_W-1:0]        div_rem_q, div_rem_d;
  logic [tws_pkg::TIMEOUT_W-1:0]   div_quo_q, div_quo_d;
  logic [tws_pkg::TD_W-1:0]        divisor_q, divisor_d;
  logic [DIV_CW-1:0]               div_cnt_q, div_cnt_d;
  logic [BW-1:0]                   bucket_q, bucket_d;
  logic [SW-1:0]                   slot_q, slot_d;
  logic [SCW-1:0]                  slot_cnt_q, slot_cnt_d;

  // Output register.
  logic                            m_valid_q;
  tws_pkg::kind_e                  m_kind_q;
  logic [tws_pkg::STATUS_W-1:0]    m_status_q;
  logic [tws_pkg::HANDLE_W-1:0]    m_handle_q;
  logic [tws_pkg::TAG_W-1:0]       m_tag_q;
  logic                            m_last_q;

  logic                            out_free;
  logic                            out_load;
  tws_pkg::kind_e                  out_kind;
  tws_pkg::status_e                out_status;
  logic [tws_pkg::HANDLE_W-1:0]    out_handle;
  logic [tws_pkg::TAG_W-1:0]       out_tag;
  logic                            out_last;

  // RAM ports.
  logic                            row_we, row_re;
  logic [BW-1:0]                   row_waddr, row_raddr;
  logic [ROW_W-1:0]                row_wdata, row_rdata;
  logic                            tag_we, tag_re;
  logic [IW-1:0]                   tag_waddr, tag_raddr;
  logic [tws_pkg::TAG_W-1:0]       tag_rdata;

  // Divider step and post-division terms.
  logic [tws_pkg::TD_W:0]          rem_shift;
  logic                            rem_ge;
  logic [tws_pkg::TD_W-1:0]        td_eff;
  logic                            too_long;
  logic [BW:0]                     bucket_sum;
  logic [BW-1:0]                   add_bucket;
  logic                            rm_in_range;

  // Handle split for remove.
  logic [tws_pkg::HANDLE_W-1:0]    rm_handle, rm_bucket, rm_base, rm_slot;
  logic [RM_PW-1:0]                rm_prod;

  // Row fields and slot search.
  logic [SLOTS_PER_BUCKET-1:0]     row_valid, row_os;
  logic [SLOTS_PER_BUCKET-1:0]     add_valid, add_os, rm_valid;
  logic                            free_found;
  logic [SW-1:0]                   free_slot;
  logic [IW-1:0]                   add_idx, tick_idx;

  logic                            s_accept;

  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == tws_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  assign td_eff = (td_q == '0) ? tws_pkg::TD_RESET : td_q;

  // Restoring division, one quotient bit per cycle.
  assign rem_shift = {div_rem_q, div_quo_q[tws_pkg::TIMEOUT_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor_q};

  assign too_long = (div_quo_q > tws_pkg::TIMEOUT_W'(NUM_BUCKETS)) ||
                    ((div_quo_q == tws_pkg::TIMEOUT_W'(NUM_BUCKETS)) && (div_rem_q != '0));
  assign bucket_sum  = {1'b0, cur_bucket_q} + div_quo_q[BW:0];
  assign add_bucket  = (bucket_sum >= NB_EXT) ? BW'(bucket_sum - NB_EXT) : bucket_sum[BW-1:0];
  assign rm_in_range = div_quo_q < tws_pkg::TIMEOUT_W'(NUM_BUCKETS);

  assign rm_handle = s_axis_tdata_i[57:49];
  assign rm_prod   = RM_PW'(rm_handle) * RM_PW'(RM_RECIP);
  assign rm_bucket = rm_prod[RM_SHIFT +: tws_pkg::HANDLE_W];
  assign rm_base   = rm_bucket * tws_pkg::HANDLE_W'(SLOTS_PER_BUCKET);
  assign rm_slot   = rm_handle - rm_base;

  assign row_valid = row_rdata[SLOTS_PER_BUCKET-1:0];
  assign row_os    = row_rdata[ROW_W-1:SLOTS_PER_BUCKET];

  // Lowest free slot of the row that was read.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (!row_valid[s]) begin
        free_found = 1'b1;
        free_slot  = SW'(s);
      end
    end
  end

  always_comb begin
    add_valid            = row_valid;
    add_os               = row_os;
    add_valid[free_slot] = 1'b1;
    add_os[free_slot]    = one_shot_q;
    rm_valid             = row_valid;
    rm_valid[slot_q]     = 1'b0;
  end

  assign add_idx  = IW'(bucket_q) * IW'(SLOTS_PER_BUCKET) + IW'(free_slot);
  assign tick_idx = IW'(bucket_q) * IW'(SLOTS_PER_BUCKET) + IW'(slot_cnt_q[SW-1:0]);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cur_bucket_d = cur_bucket_q;
    clr_d        = clr_q;
    one_shot_d   = one_shot_q;
    tag_d        = tag_q;
    div_rem_d    = div_rem_q;
    div_quo_d    = div_quo_q;
    divisor_d    = divisor_q;
    div_cnt_d    = div_cnt_q;
    bucket_d     = bucket_q;
    slot_d       = slot_q;
    slot_cnt_d   = slot_cnt_q;

    row_we    = 1'b0;
    row_waddr = bucket_q;
    row_wdata = '0;
    row_re    = 1'b0;
    row_raddr = cur_bucket_q;
    tag_we    = 1'b0;
    tag_waddr = add_idx;
    tag_re    = 1'b0;
    tag_raddr = tick_idx;

    out_load   = 1'b0;
    out_kind   = tws_pkg::KIND_ADD_REPLY;
    out_status = tws_pkg::STATUS_OK;
    out_handle = '0;
    out_tag    = '0;
    out_last   = 1'b1;

    case (state_q)
      tws_pkg::ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_q;
        if (clr_q == LAST_BUCKET) begin
          state_d = tws_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      tws_pkg::ST_IDLE: begin
        if (s_accept) begin
          mode_d     = tws_pkg::mode_e'(s_axis_tuser_i);
          one_shot_d = s_axis_tdata_i[32];
          tag_d      = s_axis_tdata_i[48:33];
          div_rem_d  = '0;
          div_cnt_d  = DIV_CW'(tws_pkg::TIMEOUT_W);
          case (tws_pkg::mode_e'(s_axis_tuser_i))
            tws_pkg::MODE_ADD: begin
              div_quo_d = s_axis_tdata_i[31:0];
              divisor_d = td_eff;
              state_d   = tws_pkg::ST_DIV;
            end
            tws_pkg::MODE_REMOVE: begin
              // Bucket and slot of the handle are ready at once.
              div_quo_d = tws_pkg::TIMEOUT_W'(rm_bucket);
              div_rem_d = tws_pkg::TD_W'(rm_slot);
              state_d   = tws_pkg::ST_POST;
            end
            tws_pkg::MODE_TICK: begin
              row_re     = 1'b1;
              row_raddr  = cur_bucket_q;
              bucket_d   = cur_bucket_q;
              slot_cnt_d = '0;
              state_d    = tws_pkg::ST_TICK_SCAN;
            end
            default: begin
              // The unused mode is dropped without a result.
              state_d = tws_pkg::ST_IDLE;
            end
          endcase
        end
      end

      tws_pkg::ST_DIV: begin
        div_rem_d = rem_ge ? tws_pkg::TD_W'(rem_shift - {1'b0, divisor_q})
                           : rem_shift[tws_pkg::TD_W-1:0];
        div_quo_d = {div_quo_q[tws_pkg::TIMEOUT_W-2:0], rem_ge};
        div_cnt_d = div_cnt_q - 1'b1;
        if (div_cnt_q == DIV_CW'(1)) begin
          state_d = tws_pkg::ST_POST;
        end
      end

      tws_pkg::ST_POST: begin
        if (mode_q == tws_pkg::MODE_ADD) begin
          if (too_long) begin
            if (out_free) begin
              out_load   = 1'b1;
              out_status = tws_pkg::STATUS_TOO_LONG;
              state_d    = tws_pkg::ST_IDLE;
            end
          end else begin
            row_re    = 1'b1;
            row_raddr = add_bucket;
            bucket_d  = add_bucket;
            state_d   = tws_pkg::ST_MODIFY;
          end
        end else begin
          // A handle whose bucket part is beyond the wheel changes nothing.
          if (rm_in_range) begin
            row_re    = 1'b1;
            row_raddr = div_quo_q[BW-1:0];
            bucket_d  = div_quo_q[BW-1:0];
            slot_d    = div_rem_q[SW-1:0];
            state_d   = tws_pkg::ST_MODIFY;
          end else if (out_free) begin
            out_load = 1'b1;
            out_kind = tws_pkg::KIND_REMOVE_REPLY;
            state_d  = tws_pkg::ST_IDLE;
          end
        end
      end

      tws_pkg::ST_MODIFY: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = tws_pkg::ST_IDLE;
          if (mode_q == tws_pkg::MODE_ADD) begin
            if (free_found) begin
              row_we     = 1'b1;
              row_wdata  = {add_os, add_valid};
              tag_we     = 1'b1;
              out_handle = tws_pkg::HANDLE_W'(add_idx);
            end else begin
              out_status = tws_pkg::STATUS_FULL;
            end
          end else begin
            row_we    = 1'b1;
            row_wdata = {row_os, rm_valid};
            out_kind  = tws_pkg::KIND_REMOVE_REPLY;
          end
        end
      end

      tws_pkg::ST_TICK_SCAN: begin
        if (slot_cnt_q == SCW'(SLOTS_PER_BUCKET)) begin
          if (out_free) begin
            // Fired one-shot entries are freed; periodic ones stay.
            row_we    = 1'b1;
            row_wdata = {row_os, row_valid & ~row_os};
            out_load  = 1'b1;
            out_kind  = tws_pkg::KIND_TICK_DONE;
            cur_bucket_d = (cur_bucket_q == LAST_BUCKET) ? '0 : cur_bucket_q + 1'b1;
            state_d   = tws_pkg::ST_IDLE;
          end
        end else if (row_valid[slot_cnt_q[SW-1:0]]) begin
          tag_re  = 1'b1;
          state_d = tws_pkg::ST_TICK_TAG;
        end else begin
          slot_cnt_d = slot_cnt_q + 1'b1;
        end
      end

      tws_pkg::ST_TICK_TAG: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = tws_pkg::KIND_FIRED;
          out_handle = tws_pkg::HANDLE_W'(tick_idx);
          out_tag    = tag_rdata;
          out_last   = 1'b0;
          slot_cnt_d = slot_cnt_q + 1'b1;
          state_d    = tws_pkg::ST_TICK_SCAN;
        end
      end

      default: begin
        state_d = tws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tws_pkg::ST_CLEAR;
      mode_q       <= tws_pkg::MODE_ADD;
      cur_bucket_q <= '0;
      clr_q        <= '0;
      td_q         <= tws_pkg::TD_RESET;
      div_cnt_q    <= '0;
      slot_cnt_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      cur_bucket_q <= cur_bucket_d;
      clr_q        <= clr_d;
      div_cnt_q    <= div_cnt_d;
      slot_cnt_q   <= slot_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        td_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    one_shot_q <= one_shot_d;
    tag_q      <= tag_d;
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    divisor_q  <= divisor_d;
    bucket_q   <= bucket_d;
    slot_q     <= slot_d;
    if (out_load) begin
      m_kind_q   <= out_kind;
      m_status_q <= out_status;
      m_handle_q <= out_handle;
      m_tag_q    <= out_tag;
      m_last_q   <= out_last;
    end
  end

  // One row per bucket: one-shot bits above valid bits.
  tws_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // Tags are only read for valid entries, so this RAM needs no clearing.
  tws_ram #(
    .WIDTH (tws_pkg::TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_q),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = tws_pkg::M_TDATA_W'({m_tag_q, m_handle_q, m_status_q});

endmodule

/* rtl/core/tws_checker.sv */
// Port-level checker for the timing wheel scheduler, bound to the top level.
// Depends on tws_pkg and timing_wheel_scheduler_macros.svh.
`include "timing_wheel_scheduler_macros.svh"

module tws_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [tws_pkg::TD_W-1:0]      cfg_data_i,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [tws_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input logic [tws_pkg::MODE_W-1:0]    s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tws_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [tws_pkg::KIND_W-1:0]    m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);

  // Only fired results leave the run open; every other kind closes it.
  `TWS_ASSERT_IMPL(a_last_by_kind, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tlast_o == (m_axis_tuser_o != tws_pkg::KIND_FIRED), "tlast does not match the result kind")

  // Error codes belong to add replies only, and come with a zero handle.
  `TWS_ASSERT_IMPL(a_error_on_add, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[1:0] != tws_pkg::STATUS_OK), (m_axis_tuser_o == tws_pkg::KIND_ADD_REPLY) && (m_axis_tdata_o[10:2] == '0), "error status outside an add reply")

  // A real command keeps the block busy for at least the next cycle.
  `TWS_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != tws_pkg::MODE_UNUSED), !s_axis_tready_o, "input accepted again right after a command")

  `TWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind timing_wheel_scheduler tws_checker u_tws_checker (.*);

/* test/timing_wheel_scheduler_checker.sv */
// Checker for the timing wheel scheduler: keeps its own copy of the wheel, predicts the
// results of every accepted item and compares them with the result stream.
// Depends on tws_pkg.
module timing_wheel_scheduler_checker
  import tws_pkg::*;
#(
  parameter int NUM_BUCKETS      = NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [TD_W-1:0]      cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // timeout [31:0], one_shot [32], tag [48:33], handle [57:49], zero [63:58]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // mode [1:0]
  input  logic [MODE_W-1:0]    s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // status [1:0], result_handle [10:2], fired_tag [26:11], zero [31:27]
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,
  // kind [1:0]
  input  logic [KIND_W-1:0]    m_axis_tuser_i,
  input  logic                 m_axis_tlast_i,
  output int                   pending_o,
  output int                   mismatch_count_o
);

  localparam int TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int S_TAG_LSB    = TIMEOUT_W + 1;
  localparam int S_HANDLE_LSB = S_TAG_LSB + TAG_W;
  localparam int M_HANDLE_LSB = STATUS_W;
  localparam int M_TAG_LSB    = STATUS_W + HANDLE_W;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [HANDLE_W-1:0]  handle;
    logic [TAG_W-1:0]     tag;
    logic                 last;
  } wheel_result_t;

  logic             slot_valid    [TOTAL_SLOTS];
  logic             slot_one_shot [TOTAL_SLOTS];
  logic [TAG_W-1:0] slot_tag      [TOTAL_SLOTS];
  int unsigned      cur_bucket;
  logic [TD_W-1:0]  tick_duration;
  wheel_result_t    wheel_results_due[$];
  int               errors;

  task automatic queue_result(kind_e kind, status_e status, logic [HANDLE_W-1:0] handle,
                              logic [TAG_W-1:0] tag, logic last);
    wheel_result_t r;
    r.kind   = kind;
    r.status = status;
    r.handle = handle;
    r.tag    = tag;
    r.last   = last;
    wheel_results_due = {wheel_results_due, r};
  endtask

  task automatic step_wheel(logic [MODE_W-1:0] mode, logic [TIMEOUT_W-1:0] timeout,
                            logic one_shot, logic [TAG_W-1:0] tag,
                            logic [HANDLE_W-1:0] handle);
    longint unsigned td;
    int unsigned     bucket;
    int unsigned     idx;
    bit              placed;
    td     = (tick_duration == '0) ? 1 : tick_duration;
    placed = 1'b0;
    case (mode)
      MODE_ADD: begin
        if (timeout > td * NUM_BUCKETS) begin
          queue_result(KIND_ADD_REPLY, STATUS_TOO_LONG, '0, '0, 1'b1);
        end else begin
          bucket = int'((cur_bucket + timeout / td) % NUM_BUCKETS);
          for (int s = 0; s < SLOTS_PER_BUCKET && !placed; s++) begin
            idx = bucket * SLOTS_PER_BUCKET + s;
            if (!slot_valid[idx]) begin
              slot_valid[idx]    = 1'b1;
              slot_one_shot[idx] = one_shot;
              slot_tag[idx]      = tag;
              placed             = 1'b1;
              queue_result(KIND_ADD_REPLY, STATUS_OK, HANDLE_W'(idx), '0, 1'b1);
            end
          end
          if (!placed) queue_result(KIND_ADD_REPLY, STATUS_FULL, '0, '0, 1'b1);
        end
      end
      MODE_TICK: begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
          idx = cur_bucket * SLOTS_PER_BUCKET + s;
          if (slot_valid[idx]) begin
            queue_result(KIND_FIRED, STATUS_OK, HANDLE_W'(idx), slot_tag[idx], 1'b0);
            if (slot_one_shot[idx]) slot_valid[idx] = 1'b0;
          end
        end
        queue_result(KIND_TICK_DONE, STATUS_OK, '0, '0, 1'b1);
        cur_bucket = (cur_bucket + 1) % NUM_BUCKETS;
      end
      MODE_REMOVE: begin
        // A handle outside the wheel changes nothing but is still acknowledged.
        if (handle / SLOTS_PER_BUCKET < NUM_BUCKETS) slot_valid[handle] = 1'b0;
        queue_result(KIND_REMOVE_REPLY, STATUS_OK, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    wheel_result_t       want;
    logic [STATUS_W-1:0] got_status;
    logic [HANDLE_W-1:0] got_handle;
    logic [TAG_W-1:0]    got_tag;
    got_status = m_axis_tdata_i[STATUS_W-1:0];
    got_handle = m_axis_tdata_i[M_HANDLE_LSB +: HANDLE_W];
    got_tag    = m_axis_tdata_i[M_TAG_LSB +: TAG_W];
    if (wheel_results_due.size() == 0) begin
      $display("%0t: unexpected result: kind %0d status %0d handle %0d tag %h last %0b",
               $time, m_axis_tuser_i, got_status, got_handle, got_tag, m_axis_tlast_i);
      errors++;
    end else begin
      want = wheel_results_due.pop_front();
      if (want.kind !== m_axis_tuser_i || want.status !== got_status ||
          want.handle !== got_handle || want.tag !== got_tag ||
          want.last !== m_axis_tlast_i) begin
        $display("%0t: result mismatch: expected kind %0d status %0d handle %0d tag %h last %0b",
                 $time, want.kind, want.status, want.handle, want.tag, want.last);
        $display("%0t:                  actual kind %0d status %0d handle %0d tag %h last %0b",
                 $time, m_axis_tuser_i, got_status, got_handle, got_tag, m_axis_tlast_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        slot_valid[i]    = 1'b0;
        slot_one_shot[i] = 1'b0;
        slot_tag[i]      = '0;
      end
      cur_bucket    = 0;
      tick_duration = TD_RESET;
      wheel_results_due.delete();
      errors = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // Results are checked before the item of the same edge is predicted.
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) tick_duration = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        step_wheel(s_axis_tuser_i, s_axis_tdata_i[TIMEOUT_W-1:0], s_axis_tdata_i[TIMEOUT_W],
                   s_axis_tdata_i[S_TAG_LSB +: TAG_W], s_axis_tdata_i[S_HANDLE_LSB +: HANDLE_W]);
      end
      pending_o        <= wheel_results_due.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

/* test/timing_wheel_scheduler_tb.sv */
// Testbench top for the timing wheel scheduler: clock, reset, directed and random items,
// tick_duration settings and the verdict. Depends on tws_pkg, the block and its checker.
module timing_wheel_scheduler_tb;
  import tws_pkg::*;

  localparam int NB  = NUM_BUCKETS_DEF;
  localparam int SPB = SLOTS_PER_BUCKET_DEF;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int PAD_W = S_TDATA_W - TIMEOUT_W - 1 - TAG_W - HANDLE_W;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [TD_W-1:0]      cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [MODE_W-1:0]    s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [KIND_W-1:0]    m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  int              pending_results;
  int              mismatch_count;
  int              src_idle_pct   = 0;
  int              sink_stall_pct = 0;
  int unsigned     ticks_sent     = 0;
  logic [TD_W-1:0] cur_td         = TD_RESET;

  timing_wheel_scheduler i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  timing_wheel_scheduler_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tuser_i   (m_axis_tuser_o),
    .m_axis_tlast_i   (m_axis_tlast_o),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(logic [MODE_W-1:0] mode, logic [TIMEOUT_W-1:0] timeout,
                           logic one_shot, logic [TAG_W-1:0] tag,
                           logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= {{PAD_W{1'b0}}, handle, tag, one_shot, timeout};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (mode == MODE_TICK) ticks_sent++;
  endtask

  // The first edge lets the checker count the item accepted at the current edge.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tick_duration(logic [TD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_td = value;
  endtask

  // Timeouts mostly land a few buckets ahead, removes mostly hit buckets near the
  // current one, so that entries fire, fill buckets and get removed while live.
  task automatic random_item();
    int unsigned         td;
    int unsigned         pick;
    int unsigned         shape;
    logic [MODE_W-1:0]   mode;
    logic [TIMEOUT_W-1:0] timeout;
    logic [HANDLE_W-1:0] handle;
    td    = (cur_td == '0) ? 1 : cur_td;
    shape = $urandom_range(99);
    if (shape < 8) timeout = $urandom();
    else if (shape < 14) timeout = td * NB;
    else if (shape < 18) timeout = td * NB + 1;
    else timeout = td * $urandom_range(12, 0) + $urandom_range(td - 1, 0);
    if ($urandom_range(99) < 80) begin
      handle = HANDLE_W'(((ticks_sent + $urandom_range(12, 0)) % NB) * SPB +
                         $urandom_range(3, 0));
    end else begin
      handle = HANDLE_W'($urandom());
    end
    pick = $urandom_range(99);
    if (pick < 42) mode = MODE_ADD;
    else if (pick < 77) mode = MODE_TICK;
    else if (pick < 95) mode = MODE_REMOVE;
    else mode = MODE_UNUSED;
    send_item(mode, timeout, 1'($urandom_range(1, 0)), TAG_W'($urandom()), handle);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill bucket 0 with a mix of one-shot and periodic entries, then overflow it.
    send_item(MODE_ADD, '0, 1'b1, 16'hFFFF, '0);
    send_item(MODE_ADD, NB, 1'b0, 16'h0000, '1);
    send_item(MODE_ADD, NB + 1, 1'b1, 16'h5A5A, '0);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, '1);
    for (int i = 0; i < 7; i++) begin
      send_item(MODE_ADD, (i % 2) ? NB : 0, 1'(i % 2), TAG_W'(16'h1000 + i), '0);
    end
    send_item(MODE_TICK, '0, 1'b0, '0, '0);
    send_item(MODE_REMOVE, '0, 1'b0, '0, '1);
    send_item(MODE_REMOVE, '0, 1'b0, '0, HANDLE_W'(1));
    send_item(MODE_UNUSED, '1, 1'b1, '1, '1);
    send_item(MODE_ADD, 5, 1'b1, 16'h1234, '0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          write_tick_duration('0);
        end
        1: begin
          src_idle_pct   = 79;
          sink_stall_pct = 0;
          write_tick_duration('1);
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 79;
          write_tick_duration(16'd3);
        end
        default: begin
          src_idle_pct   = 26;
          sink_stall_pct = 26;
          write_tick_duration(16'd1);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item();
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/tws_ram.sv
rtl/core/timing_wheel_scheduler.sv
rtl/core/tws_checker.sv
test/timing_wheel_scheduler_checker.sv
test/timing_wheel_scheduler_tb.sv
